// ===== src/csa_pkg.sv =====
package csa_pkg;

   localparam int NUM_BUCKETS_DEF = 1024;
   localparam int NUM_COLUMNS_DEF = 64;

   localparam int FUNC_W      = 2;
   localparam int ROW_IDX_W   = 31;
   localparam int COL_W       = 6;
   localparam int VAL_W       = 32;
   localparam int BUCKET_W    = 10;
   localparam int CELL_W      = 48;
   localparam int WORD_W      = CELL_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int BITS_W      = 4;
   localparam int SEED_W      = 31;
   localparam int RECIP_SHIFT = 20;

   localparam logic [FUNC_W-1:0] FUNC_ACCUM      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MULT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_ADD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_BITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ONE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_TWO    = 3'd4;

   localparam logic [BITS_W-1:0] BUCKET_BITS_MIN   = 4'd1;
   localparam logic [BITS_W-1:0] BUCKET_BITS_MAX   = 4'd10;
   localparam logic [BITS_W-1:0] BUCKET_BITS_RESET = 4'd10;

   localparam logic [CELL_W-1:0] CELL_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [CELL_W-1:0] CELL_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic [63:0]         hash_mult;
      logic [63:0]         hash_add;
      logic [BITS_W-1:0]   bucket_bits;
      logic [SEED_W-1:0]   seed_one;
      logic [SEED_W-1:0]   seed_two;
   } cfg_type;

endpackage

// ===== src/csa_channels.sv =====
interface csa_req_if;
   logic                               valid;
   logic                               ready;
   logic [csa_pkg::FUNC_W-1:0]         func;
   logic [csa_pkg::ROW_IDX_W-1:0]      row_index;
   logic [csa_pkg::COL_W-1:0]          column;
   logic signed [csa_pkg::VAL_W-1:0]   entry_value;
   logic [csa_pkg::BUCKET_W-1:0]       bucket;

   modport source (output valid, func, row_index, column, entry_value, bucket, input ready);
   modport sink (input valid, func, row_index, column, entry_value, bucket, output ready);
endinterface

interface csa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [csa_pkg::CELL_W-1:0]  cell_value;
   logic                               saturated;

   modport source (output valid, cell_value, saturated, input ready);
   modport sink (input valid, cell_value, saturated, output ready);
endinterface

interface csa_csr_if;
   logic                               valid;
   logic                               ready;
   logic [csa_pkg::CSR_IDX_W-1:0]      index;
   logic [csa_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/csa_ram.sv =====
module csa_ram #(
   parameter int WIDTH = csa_pkg::WORD_W,
   parameter int DEPTH = csa_pkg::NUM_BUCKETS_DEF * csa_pkg::NUM_COLUMNS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/csa_csr.sv =====
module csa_csr (
   input  logic              clock,
   input  logic              reset,
   csa_csr_if.sink           csr_if,
   output csa_pkg::cfg_type  cfg
);

   csa_pkg::cfg_type cfg_ff;
   csa_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            csa_pkg::CSR_HASH_MULT:   cfg_in.hash_mult   = csr_if.data;
            csa_pkg::CSR_HASH_ADD:    cfg_in.hash_add    = csr_if.data;
            csa_pkg::CSR_BUCKET_BITS: cfg_in.bucket_bits = csr_if.data[csa_pkg::BITS_W-1:0];
            csa_pkg::CSR_SEED_ONE:    cfg_in.seed_one    = csr_if.data[csa_pkg::SEED_W-1:0];
            csa_pkg::CSR_SEED_TWO:    cfg_in.seed_two    = csr_if.data[csa_pkg::SEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_mult   <= '0;
         cfg_ff.hash_add    <= '0;
         cfg_ff.bucket_bits <= csa_pkg::BUCKET_BITS_RESET;
         cfg_ff.seed_one    <= '0;
         cfg_ff.seed_two    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/csa_hash.sv =====
module csa_hash #(
   parameter int NUM_BUCKETS = csa_pkg::NUM_BUCKETS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [csa_pkg::ROW_IDX_W-1:0]      row,
   input  csa_pkg::cfg_type                   cfg,
   output logic                               done,
   output logic                               positive,
   output logic [$clog2(NUM_BUCKETS)-1:0]     bucket
);

   localparam int ROW_W = $clog2(NUM_BUCKETS);
   localparam int RECIP = (1 << csa_pkg::RECIP_SHIFT) / NUM_BUCKETS;
   localparam int BW    = csa_pkg::BUCKET_W;
   localparam int BITS_W_L = csa_pkg::BITS_W;

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_LO   = 3'd1;
   localparam logic [2:0] H_HI   = 3'd2;
   localparam logic [2:0] H_SQ   = 3'd3;
   localparam logic [2:0] H_CUBE = 3'd4;
   localparam logic [2:0] H_DIV  = 3'd5;
   localparam logic [2:0] H_MUL  = 3'd6;
   localparam logic [2:0] H_REM  = 3'd7;

   logic [2:0]                     step_ff, step_in;
   logic                           done_ff, done_in;
   logic [csa_pkg::ROW_IDX_W-1:0]  row_ff, row_in;
   logic [62:0]                    lo_ff, lo_in;
   logic [31:0]                    hi_ff, hi_in;
   logic [30:0]                    sq_ff, sq_in;
   logic [30:0]                    cube_ff, cube_in;
   logic [63:0]                    sum_ff, sum_in;
   logic [BW-1:0]                  raw_ff, raw_in;
   logic [BW-1:0]                  q_ff, q_in;
   logic [BW-1:0]                  qr_ff, qr_in;
   logic                           pos_ff, pos_in;
   logic [ROW_W-1:0]               bucket_ff, bucket_in;

   logic [31:0]    a_op, b_op;
   logic [63:0]    prod;
   logic [BITS_W_L-1:0] bits_eff;
   logic [6:0]     shamt;
   logic [63:0]    shifted;
   logic [BW-1:0]  rem;
   logic [BW:0]    wrapped;

   // one shared multiplier, operands chosen by step
   always_comb begin
      case (step_ff)
         H_LO:    begin a_op = cfg.hash_mult[31:0];  b_op = {1'b0, row_ff}; end
         H_HI:    begin a_op = cfg.hash_mult[63:32]; b_op = {1'b0, row_ff}; end
         H_SQ:    begin a_op = {1'b0, row_ff};       b_op = {1'b0, row_ff}; end
         H_CUBE:  begin a_op = {1'b0, sq_ff};        b_op = {1'b0, row_ff}; end
         H_DIV:   begin a_op = 32'(raw_ff);          b_op = 32'(RECIP);     end
         H_MUL:   begin a_op = 32'(q_ff);            b_op = 32'(NUM_BUCKETS); end
         default: begin a_op = '0;                   b_op = '0;             end
      endcase
   end

   assign prod = 64'(a_op) * 64'(b_op);

   always_comb begin
      if (cfg.bucket_bits < csa_pkg::BUCKET_BITS_MIN) begin
         bits_eff = csa_pkg::BUCKET_BITS_MIN;
      end else if (cfg.bucket_bits > csa_pkg::BUCKET_BITS_MAX) begin
         bits_eff = csa_pkg::BUCKET_BITS_MAX;
      end else begin
         bits_eff = cfg.bucket_bits;
      end
   end

   assign shamt   = 7'd64 - 7'(bits_eff);
   assign shifted = sum_ff >> shamt;
   assign rem     = raw_ff - qr_ff;
   // reciprocal estimate is low by at most one
   assign wrapped = ((BW+1)'(rem) >= (BW+1)'(NUM_BUCKETS)) ?
                    (BW+1)'(rem) - (BW+1)'(NUM_BUCKETS) : (BW+1)'(rem);

   always_comb begin
      step_in   = step_ff;
      done_in   = 1'b0;
      row_in    = row_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      sq_in     = sq_ff;
      cube_in   = cube_ff;
      sum_in    = sum_ff;
      raw_in    = raw_ff;
      q_in      = q_ff;
      qr_in     = qr_ff;
      pos_in    = pos_ff;
      bucket_in = bucket_ff;
      case (step_ff)
         H_IDLE: begin
            if (start) begin
               row_in  = row;
               step_in = H_LO;
            end
         end
         H_LO: begin
            lo_in   = prod[62:0];
            step_in = H_HI;
         end
         H_HI: begin
            hi_in   = prod[31:0];
            step_in = H_SQ;
         end
         H_SQ: begin
            sq_in   = prod[30:0];
            sum_in  = 64'(lo_ff) + {hi_ff, 32'b0} + cfg.hash_add;
            step_in = H_CUBE;
         end
         H_CUBE: begin
            cube_in = prod[30:0];
            raw_in  = shifted[BW-1:0];
            step_in = H_DIV;
         end
         H_DIV: begin
            pos_in  = (^(cfg.seed_one & row_ff)) ^ (^(cfg.seed_two & cube_ff));
            q_in    = prod[csa_pkg::RECIP_SHIFT +: BW];
            step_in = H_MUL;
         end
         H_MUL: begin
            qr_in   = prod[BW-1:0];
            step_in = H_REM;
         end
         H_REM: begin
            bucket_in = wrapped[ROW_W-1:0];
            done_in   = 1'b1;
            step_in   = H_IDLE;
         end
         default: step_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= H_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      row_ff    <= row_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      sq_ff     <= sq_in;
      cube_ff   <= cube_in;
      sum_ff    <= sum_in;
      raw_ff    <= raw_in;
      q_ff      <= q_in;
      qr_ff     <= qr_in;
      pos_ff    <= pos_in;
      bucket_ff <= bucket_in;
   end

   assign done     = done_ff;
   assign positive = pos_ff;
   assign bucket   = bucket_ff;

endmodule

// ===== src/count_sketch_accumulator_unit.sv =====
// Count sketch accumulator. Requests arrive on req_if (valid/ready): func selects
// accumulate, read cell, or read and clear cell. Accumulate hashes row_index to a
// bucket and a sign, then adds +/-entry_value into cell (bucket, column) of the
// sketch, saturating at 48 bits. Reads return cell_value and the saturation mark
// on rsp_if; accumulate gives no response. Hash and sign seeds are written on
// csr_if, which is always ready; write it only while the block is idle.
// One request is in flight at a time. Accumulate runs from accept through the
// hash unit, which runs its steps through one shared 32x32 multiplier, then
// through address, store read and write back, and returns to idle. A read
// passes the address, store read and modify steps to its response step; a read
// of a bucket or column outside the store goes straight to the response step
// and responds with zeros.
// The response sits in an output register; a new request is taken while it
// waits, and a second read stalls only at its response step until rsp_if.ready.
// After reset the sketch store is swept to zero, one cell per cycle, across all
// NUM_BUCKETS*NUM_COLUMNS cells (65536 by default); req_if.ready stays low
// during the sweep.
module count_sketch_accumulator_unit #(
   parameter int NUM_BUCKETS = csa_pkg::NUM_BUCKETS_DEF,
   parameter int NUM_COLUMNS = csa_pkg::NUM_COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   csa_req_if.sink     req_if,
   csa_rsp_if.source   rsp_if,
   csa_csr_if.sink     csr_if
);

   localparam int CELLS = NUM_BUCKETS * NUM_COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int ROW_W = $clog2(NUM_BUCKETS);
   localparam int WW    = csa_pkg::WORD_W;
   localparam int CW    = csa_pkg::CELL_W;

   localparam logic [2:0] T_CLEAR = 3'd0;
   localparam logic [2:0] T_IDLE  = 3'd1;
   localparam logic [2:0] T_HASH  = 3'd2;
   localparam logic [2:0] T_ADDR  = 3'd3;
   localparam logic [2:0] T_READ  = 3'd4;
   localparam logic [2:0] T_MOD   = 3'd5;
   localparam logic [2:0] T_RESP  = 3'd6;

   csa_pkg::cfg_type cfg;

   logic [2:0]                        state_ff, state_in;
   logic [AW-1:0]                     clr_ff, clr_in;
   logic [csa_pkg::FUNC_W-1:0]        func_ff, func_in;
   logic [csa_pkg::COL_W-1:0]         col_ff, col_in;
   logic [csa_pkg::VAL_W-1:0]         value_ff, value_in;
   logic [csa_pkg::BUCKET_W-1:0]      bucket_ff, bucket_in;
   logic [AW-1:0]                     addr_ff, addr_in;
   logic [WW-1:0]                     res_ff, res_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]                     rsp_word_ff, rsp_word_in;

   logic              accept;
   logic              col_oob;
   logic              bucket_oob;
   logic              hash_start;
   logic              hash_done;
   logic              hash_pos;
   logic [ROW_W-1:0]  hash_bucket;
   logic [31:0]       addr_full;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [WW-1:0]     ram_wr_data;
   logic              ram_rd_en;
   logic [WW-1:0]     ram_rd_data;

   logic [32:0]       add_val;
   logic [CW:0]       sum;
   logic              over_pos;
   logic              over_neg;
   logic [CW-1:0]     new_cell;

   csa_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   csa_hash #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .row      (req_if.row_index),
      .cfg      (cfg),
      .done     (hash_done),
      .positive (hash_pos),
      .bucket   (hash_bucket)
   );

   csa_ram #(
      .WIDTH (WW),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready = (state_ff == T_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign col_oob      = 32'(req_if.column) >= 32'(NUM_COLUMNS);
   assign bucket_oob   = 32'(req_if.bucket) >= 32'(NUM_BUCKETS);
   assign hash_start   = accept && (req_if.func == csa_pkg::FUNC_ACCUM) && !col_oob;
   assign addr_full    = 32'(bucket_ff) * 32'(NUM_COLUMNS) + 32'(col_ff);
   assign ram_rd_en    = (state_ff == T_READ);

   // signed add with saturation; the mark sticks until the cell is cleared
   assign add_val  = hash_pos ? {value_ff[31], value_ff} : 33'd0 - {value_ff[31], value_ff};
   assign sum      = {ram_rd_data[CW-1], ram_rd_data[CW-1:0]} +
                     {{(CW-32){add_val[32]}}, add_val};
   assign over_pos = !sum[CW] && sum[CW-1];
   assign over_neg = sum[CW] && !sum[CW-1];
   assign new_cell = over_pos ? csa_pkg::CELL_MAX :
                     over_neg ? csa_pkg::CELL_MIN : sum[CW-1:0];

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      if (state_ff == T_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
      end else if (state_ff == T_MOD) begin
         if (func_ff == csa_pkg::FUNC_ACCUM) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {ram_rd_data[CW] | over_pos | over_neg, new_cell};
         end else if (func_ff == csa_pkg::FUNC_READ_CLEAR) begin
            ram_wr_en   = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      col_in       = col_ff;
      value_in     = value_ff;
      bucket_in    = bucket_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         T_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = T_IDLE;
            end
         end
         T_IDLE: begin
            if (accept) begin
               func_in   = req_if.func;
               col_in    = req_if.column;
               value_in  = req_if.entry_value;
               bucket_in = req_if.bucket;
               if (req_if.func == csa_pkg::FUNC_ACCUM) begin
                  if (!col_oob) begin
                     state_in = T_HASH;
                  end
               end else if (req_if.func == csa_pkg::FUNC_READ ||
                            req_if.func == csa_pkg::FUNC_READ_CLEAR) begin
                  if (col_oob || bucket_oob) begin
                     res_in   = '0;
                     state_in = T_RESP;
                  end else begin
                     state_in = T_ADDR;
                  end
               end
            end
         end
         T_HASH: begin
            if (hash_done) begin
               bucket_in = csa_pkg::BUCKET_W'(hash_bucket);
               state_in  = T_ADDR;
            end
         end
         T_ADDR: begin
            addr_in  = addr_full[AW-1:0];
            state_in = T_READ;
         end
         T_READ: begin
            state_in = T_MOD;
         end
         T_MOD: begin
            if (func_ff == csa_pkg::FUNC_ACCUM) begin
               state_in = T_IDLE;
            end else begin
               res_in   = ram_rd_data;
               state_in = T_RESP;
            end
         end
         T_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      col_ff      <= col_in;
      value_ff    <= value_in;
      bucket_ff   <= bucket_in;
      addr_ff     <= addr_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cell_value = rsp_word_ff[CW-1:0];
   assign rsp_if.saturated  = rsp_word_ff[CW];

   a_hash_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == T_HASH))
      else $error("hash result arrived outside the hash wait");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == T_MOD || state_ff == T_CLEAR))
      else $error("store written outside clear sweep or modify step");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_READ) |-> (addr_ff <= AW'(CELLS - 1)))
      else $error("store address beyond sketch");

   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_MOD && func_ff != csa_pkg::FUNC_ACCUM) |=> (state_ff == T_RESP))
      else $error("read request did not move to response");

endmodule

// ===== tb/tb.sv =====
module tb;

   localparam int LIMIT    = 1_000_000;
   localparam int SETTLE   = 40;
   localparam int PHASES   = 6;
   localparam int BURST    = 260;
   localparam int BIG_ADDS = 16;
   localparam int HOLD     = 300;
   localparam int CELLS    = csa_pkg::NUM_BUCKETS_DEF * csa_pkg::NUM_COLUMNS_DEF;

   localparam logic [csa_pkg::FUNC_W-1:0]    FUNC_SPARE = 2'd3;
   localparam logic [csa_pkg::CSR_IDX_W-1:0] CSR_SPARE  = 3'd7;

   localparam logic signed [49:0] SUM_HI = 50'sh7FFF_FFFF_FFFF;
   localparam logic signed [49:0] SUM_LO = -SUM_HI - 50'sd1;

   typedef struct packed {
      logic [csa_pkg::FUNC_W-1:0]        func;
      logic [csa_pkg::ROW_IDX_W-1:0]     row_index;
      logic [csa_pkg::COL_W-1:0]         column;
      logic signed [csa_pkg::VAL_W-1:0]  entry_value;
      logic [csa_pkg::BUCKET_W-1:0]      bucket;
   } sketch_req_type;

   typedef struct packed {
      logic signed [csa_pkg::CELL_W-1:0] value;
      logic                              sat;
   } cell_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   csa_req_if req_ch();
   csa_rsp_if rsp_ch();
   csa_csr_if csr_ch();

   count_sketch_accumulator_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // mirror of the block: configuration and sketch contents
   logic [63:0]                    cfg_mult     = '0;
   logic [63:0]                    cfg_add      = '0;
   logic [csa_pkg::BITS_W-1:0]     cfg_bits     = csa_pkg::BUCKET_BITS_RESET;
   logic [csa_pkg::SEED_W-1:0]     cfg_seed_one = '0;
   logic [csa_pkg::SEED_W-1:0]     cfg_seed_two = '0;
   bit signed [csa_pkg::CELL_W-1:0] sketch_cells [CELLS];
   bit                             sat_marks [CELLS];

   sketch_req_type req_backlog[$];
   sketch_req_type req_head;
   cell_word_type  cell_reads_due[$];
   cell_word_type  due_word;

   int   items_queued   = 0;
   int   items_accepted = 0;
   int   errors         = 0;
   int   cycle_count    = 0;
   int   hold_left      = 0;
   logic req_fire       = 1'b0;
   logic csr_fire       = 1'b0;
   logic calm           = 1'b0;
   logic hold_wanted    = 1'b0;
   logic hold_done      = 1'b0;

   function automatic logic [csa_pkg::BUCKET_W-1:0] bucket_for(
      input logic [csa_pkg::ROW_IDX_W-1:0] row);
      logic [csa_pkg::BITS_W-1:0] nbits;
      logic [63:0]                h;
      nbits = cfg_bits;
      if (nbits < csa_pkg::BUCKET_BITS_MIN) nbits = csa_pkg::BUCKET_BITS_MIN;
      if (nbits > csa_pkg::BUCKET_BITS_MAX) nbits = csa_pkg::BUCKET_BITS_MAX;
      h = cfg_mult * {33'd0, row} + cfg_add;
      h = h >> (64 - nbits);
      return h[csa_pkg::BUCKET_W-1:0];
   endfunction

   function automatic bit sign_plus(input logic [csa_pkg::ROW_IDX_W-1:0] row);
      logic [csa_pkg::ROW_IDX_W-1:0] sq;
      logic [csa_pkg::ROW_IDX_W-1:0] cube;
      sq   = row * row;
      cube = sq * row;
      return (^(cfg_seed_one & row)) ^ (^(cfg_seed_two & cube));
   endfunction

   task automatic sketch_apply(input sketch_req_type q);
      logic [15:0]        addr;
      logic signed [49:0] delta;
      logic signed [49:0] total;
      cell_word_type      word;
      case (q.func)
         csa_pkg::FUNC_ACCUM: begin
            addr  = {bucket_for(q.row_index), q.column};
            delta = signed'(q.entry_value);
            if (!sign_plus(q.row_index)) delta = -delta;
            total = sketch_cells[addr];
            total = total + delta;
            if (total > SUM_HI) begin
               total = SUM_HI;
               sat_marks[addr] = 1'b1;
            end else if (total < SUM_LO) begin
               total = SUM_LO;
               sat_marks[addr] = 1'b1;
            end
            sketch_cells[addr] = total[csa_pkg::CELL_W-1:0];
         end
         csa_pkg::FUNC_READ, csa_pkg::FUNC_READ_CLEAR: begin
            addr       = {q.bucket, q.column};
            word.value = sketch_cells[addr];
            word.sat   = sat_marks[addr];
            cell_reads_due.push_back(word);
            if (q.func == csa_pkg::FUNC_READ_CLEAR) begin
               sketch_cells[addr] = '0;
               sat_marks[addr]    = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic post_req(input logic [csa_pkg::FUNC_W-1:0] f,
                           input logic [csa_pkg::ROW_IDX_W-1:0] r,
                           input logic [csa_pkg::COL_W-1:0] c,
                           input logic [csa_pkg::VAL_W-1:0] v,
                           input logic [csa_pkg::BUCKET_W-1:0] b);
      sketch_req_type q;
      q.func        = f;
      q.row_index   = r;
      q.column      = c;
      q.entry_value = v;
      q.bucket      = b;
      req_backlog.push_back(q);
      items_queued++;
   endtask

   task automatic csr_write(input logic [csa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] word);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= word;
      do @(negedge clock); while (!csr_fire);
      csr_ch.valid <= 1'b0;
   endtask

   // hold until every request is taken and every read has answered, then let
   // accumulates still in the pipeline finish
   task automatic wait_idle();
      do @(negedge clock);
      while (items_accepted != items_queued || cell_reads_due.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
            req_head = req_backlog.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.func        <= req_head.func;
            req_ch.row_index   <= req_head.row_index;
            req_ch.column      <= req_head.column;
            req_ch.entry_value <= req_head.entry_value;
            req_ch.bucket      <= req_head.bucket;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response sink, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD;
         hold_done    <= 1'b1;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   // monitor: check responses, advance the mirror on accepted requests and writes
   always @(posedge clock) begin
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      csr_fire <= !reset && csr_ch.valid && csr_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (cell_reads_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR cycle %0d: response value=%0d sat=%0b with no read outstanding",
                           cycle_count, rsp_ch.cell_value, rsp_ch.saturated);
            end else begin
               due_word = cell_reads_due.pop_front();
               if (rsp_ch.cell_value !== due_word.value || rsp_ch.saturated !== due_word.sat) begin
                  errors++;
                  if (errors <= 10)
                     $display("ERROR cycle %0d: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                              cycle_count, due_word.value, due_word.sat,
                              rsp_ch.cell_value, rsp_ch.saturated);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            items_accepted++;
            sketch_apply({req_ch.func, req_ch.row_index, req_ch.column,
                          req_ch.entry_value, req_ch.bucket});
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               csa_pkg::CSR_HASH_MULT:   cfg_mult     = csr_ch.data;
               csa_pkg::CSR_HASH_ADD:    cfg_add      = csr_ch.data;
               csa_pkg::CSR_BUCKET_BITS: cfg_bits     = csr_ch.data[csa_pkg::BITS_W-1:0];
               csa_pkg::CSR_SEED_ONE:    cfg_seed_one = csr_ch.data[csa_pkg::SEED_W-1:0];
               csa_pkg::CSR_SEED_TWO:    cfg_seed_two = csr_ch.data[csa_pkg::SEED_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int                               p;
      int                               n;
      int                               pick;
      logic [csa_pkg::ROW_IDX_W-1:0]    row_pool [8];
      logic [csa_pkg::COL_W-1:0]        col_pool [4];
      logic [csa_pkg::FUNC_W-1:0]       f;
      logic [csa_pkg::ROW_IDX_W-1:0]    r;
      logic [csa_pkg::COL_W-1:0]        c;
      logic [csa_pkg::VAL_W-1:0]        v;
      logic [csa_pkg::BUCKET_W-1:0]     b;
      logic [63:0]                      w_mult;
      logic [63:0]                      w_add;
      logic [63:0]                      w_bits;
      logic [63:0]                      w_s1;
      logic [63:0]                      w_s2;

      req_ch.valid       = 1'b0;
      req_ch.func        = csa_pkg::FUNC_ACCUM;
      req_ch.row_index   = '0;
      req_ch.column      = '0;
      req_ch.entry_value = '0;
      req_ch.bucket      = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = csa_pkg::CSR_HASH_MULT;
      csr_ch.data        = '0;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset configuration: every row lands in bucket 0 with a negative sign
      calm = 1'b1;
      post_req(csa_pkg::FUNC_READ, 0, 0, 0, 0);
      post_req(csa_pkg::FUNC_ACCUM, 0, 0, 32'h7FFF_FFFF, 0);
      post_req(csa_pkg::FUNC_ACCUM, '1, 0, 32'h8000_0000, '1);
      post_req(csa_pkg::FUNC_READ, '1, 0, 0, 0);
      post_req(csa_pkg::FUNC_ACCUM, 5, '1, '1, 0);
      post_req(FUNC_SPARE, '1, '1, '1, '1);
      post_req(csa_pkg::FUNC_READ_CLEAR, 0, '1, 0, 0);
      post_req(csa_pkg::FUNC_READ, 0, '1, 0, 0);
      post_req(csa_pkg::FUNC_READ, 0, '1, 0, '1);
      post_req(csa_pkg::FUNC_READ_CLEAR, 0, 0, 0, 0);

      // pile large values onto cell (0,0), step it by one, then clear
      for (n = 0; n < BIG_ADDS; n++) begin
         r = csa_pkg::ROW_IDX_W'($urandom);
         b = csa_pkg::BUCKET_W'($urandom);
         post_req(csa_pkg::FUNC_ACCUM, r, 0, 32'h8000_0000, b);
      end
      post_req(csa_pkg::FUNC_ACCUM, 0, 0, 32'd1, 0);
      post_req(csa_pkg::FUNC_READ, 0, 0, 0, 0);
      post_req(csa_pkg::FUNC_READ_CLEAR, 0, 0, 0, 0);
      post_req(csa_pkg::FUNC_READ, 0, 0, 0, 0);
      wait_idle();

      for (p = 1; p <= PHASES; p++) begin
         // first phase runs without idling on either side
         if (p == 2) calm = 1'b0;
         w_mult = {$urandom, $urandom};
         w_add  = {$urandom, $urandom};
         w_bits = {$urandom, $urandom};
         w_s1   = {$urandom, $urandom};
         w_s2   = {$urandom, $urandom};
         case (p)
            1: begin
               w_mult = '1;
               w_add  = '1;
               w_bits = 64'hFFFF_FFFF_FFFF_FFF0;
               w_s1   = '1;
               w_s2   = '0;
            end
            2: begin
               w_mult = w_mult | 64'd1;
               w_add  = '0;
               w_bits = w_bits | 64'hF;
               w_s1   = '0;
               w_s2   = '1;
            end
            3: w_bits = {60'd0, csa_pkg::BUCKET_BITS_MAX};
            4: w_bits = {60'd0, csa_pkg::BUCKET_BITS_MIN};
            5: w_bits = 64'd11;
            default: ;
         endcase
         csr_write(csa_pkg::CSR_HASH_MULT, w_mult);
         csr_write(csa_pkg::CSR_HASH_ADD, w_add);
         csr_write(csa_pkg::CSR_BUCKET_BITS, w_bits);
         csr_write(csa_pkg::CSR_SEED_ONE, w_s1);
         csr_write(csa_pkg::CSR_SEED_TWO, w_s2);
         if (p == 1) csr_write(CSR_SPARE, {$urandom, $urandom});

         // a few rows and columns per phase, so reads land on cells that were hit
         row_pool[0] = '0;
         row_pool[1] = '1;
         for (n = 2; n < 8; n++) row_pool[n] = csa_pkg::ROW_IDX_W'($urandom);
         col_pool[0] = '0;
         col_pool[1] = '1;
         col_pool[2] = csa_pkg::COL_W'($urandom);
         col_pool[3] = csa_pkg::COL_W'($urandom);

         if (p == 3) hold_wanted = 1'b1;

         n = 0;
         while (n < BURST) begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0) r = csa_pkg::ROW_IDX_W'($urandom);
            else r = row_pool[$urandom_range(7)];
            if ($urandom_range(9) == 0) c = csa_pkg::COL_W'($urandom);
            else c = col_pool[$urandom_range(3)];
            case ($urandom_range(7))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               default: v = $urandom;
            endcase
            if ($urandom_range(4) == 0) b = csa_pkg::BUCKET_W'($urandom);
            else b = bucket_for(r);
            if (pick < 60) f = csa_pkg::FUNC_ACCUM;
            else if (pick < 80) f = csa_pkg::FUNC_READ;
            else if (pick < 95) f = csa_pkg::FUNC_READ_CLEAR;
            else f = FUNC_SPARE;
            post_req(f, r, c, v, b);
            if (f != FUNC_SPARE) n++;
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/csa_pkg.sv
src/csa_channels.sv
src/csa_ram.sv
src/csa_csr.sv
src/csa_hash.sv
src/count_sketch_accumulator_unit.sv
tb/tb.sv
